@@ rtl/sdtq_pkg.sv @@
// ============================================================================
// sdtq_pkg
// Shared types and constants of the sorted deadline timer queue.
// ============================================================================
package sdtq_pkg;

    localparam int TIME_W = 64;
    localparam int TAG_W = 16;
    localparam int DELAY_W = 32;
    localparam int TPS_W = 32;
    localparam int KIND_W = 2;

    // upper bound on expiry words per tick
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS);

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [KIND_W-1:0] t_kind;

    // operation codes (s_axis_tuser)
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD = 1'b1;

    // result kinds (m_axis_tuser)
    localparam t_kind KIND_EXPIRED = 2'd0;
    localparam t_kind KIND_ADD_OK = 2'd1;
    localparam t_kind KIND_ADD_FULL = 2'd2;
    localparam t_kind KIND_IDLE_TICK = 2'd3;

    // register index (paddr[2])
    localparam logic REG_IDX_TPS = 1'b0;
    localparam logic [TPS_W-1:0] TPS_RESET = 32'd62500000;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

@@ rtl/sdtq_cell.sv @@
// ============================================================================
// sdtq_cell
// One slot of the sorted queue: holds a deadline and a tag, shifts toward
// the tail on insert and toward the head on pop.
// ============================================================================
module sdtq_cell
    import sdtq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,       // slot holds a live entry
    input  t_time     i_new_dl,
    input  t_tag      i_new_tag,
    input  logic      i_prev_ins,  // neighbor toward head also moves
    input  t_time     i_prev_dl,
    input  t_tag      i_prev_tag,
    input  t_time     i_next_dl,
    input  t_tag      i_next_tag,
    output logic      o_ins,
    output t_time     o_dl,
    output t_tag      o_tag
);

    t_time r_dl;
    t_tag  r_tag;

    // new entry belongs at or before this slot (ties stay behind)
    assign o_ins = !i_occ || (i_new_dl < r_dl);
    assign o_dl = r_dl;
    assign o_tag = r_tag;

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && o_ins) begin
            if (i_prev_ins) begin
                r_dl <= i_prev_dl;
                r_tag <= i_prev_tag;
            end else begin
                r_dl <= i_new_dl;
                r_tag <= i_new_tag;
            end
        end else if (i_ctl.pop) begin
            r_dl <= i_next_dl;
            r_tag <= i_next_tag;
        end
    end

endmodule

@@ rtl/sorted_deadline_timer_queue_top.sv @@
// ============================================================================
// sorted_deadline_timer_queue_top
// One-shot timer queue kept sorted by absolute deadline in a row of cells.
// ============================================================================
// Usage:
//   s_axis carries one word per command: tuser selects tick or add, tdata
//   carries the tag and the delay in seconds. m_axis returns result words;
//   tuser is the result kind, tlast closes the results of one command.
//   The APB port holds ticks_per_second (address 0).
// Timing:
//   An add: the accept cycle registers delay * ticks, then the insert step
//   forms the deadline, inserts it into the cell row and loads the result
//   word. A tick returns k result words (at most 16): the expiry walk pops
//   one head entry per cycle while the output register can be loaded.
//   s_axis_tready is high while no command is in progress; a new command is
//   taken even while the last result word still waits in the output
//   register.
// Reset: the time counter and the entry count clear, the queue is empty and
//   ticks_per_second returns to 62500000. No clearing pass is needed.
// Stall: while m_axis_tready is low, a pending word holds and the command
//   in progress waits behind it before its next step.
// ============================================================================
module sorted_deadline_timer_queue_top
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] task_tag, [47:16] delay_seconds
    input  logic        s_axis_tuser,   // [0] operation
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] expired_tag, [16] timer_armed, zero pad
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast,   // last_result
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_EXPIRE = 2'd3;

    logic [1:0]           r_state, n_state;
    t_time                r_time, n_time;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [RES_CNT_W-1:0] r_n, n_n;
    logic [TPS_W-1:0]     r_tps;
    t_time                r_prod;
    t_tag                 r_tag;

    logic  r_out_valid, n_out_valid;
    t_kind r_out_kind, n_out_kind;
    t_tag  r_out_tag, n_out_tag;
    logic  r_out_armed, n_out_armed;
    logic  r_out_last, n_out_last;

    t_cell_ctl w_ctl;
    t_time     w_new_dl;
    logic      w_ins [QUEUE_DEPTH];
    t_time     w_dl [QUEUE_DEPTH];
    t_tag      w_tag [QUEUE_DEPTH];

    logic w_accept, w_can_load, w_full, w_head_due, w_next_due, w_cfg_wr;

    // ------------------------------------------------------------------
    // register port
    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_TPS);
    assign prdata = (paddr[2] == REG_IDX_TPS) ? r_tps : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (w_cfg_wr) begin
            r_tps <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // handshake and status
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_can_load = !r_out_valid || m_axis_tready;
    assign w_full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_new_dl = r_time + r_prod;

    // head checks for the expiry walk
    assign w_head_due = (r_count != '0) && (w_dl[0] <= r_time);
    assign w_next_due = (r_count > CNT_W'(1)) && (w_dl[1] <= r_time)
                        && (r_n != RES_CNT_W'(MAX_RESULTS - 1));

    assign w_ctl.insert = (r_state == ST_INSERT) && w_can_load;
    assign w_ctl.pop = (r_state == ST_EXPIRE) && w_can_load && w_head_due;

    // ------------------------------------------------------------------
    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NEXT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

        sdtq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_occ     (r_count > CNT_W'(i)),
            .i_new_dl  (w_new_dl),
            .i_new_tag (r_tag),
            .i_prev_ins((i != 0) && w_ins[PREV]),
            .i_prev_dl (w_dl[PREV]),
            .i_prev_tag(w_tag[PREV]),
            .i_next_dl (w_dl[NEXT]),
            .i_next_tag(w_tag[NEXT]),
            .o_ins     (w_ins[i]),
            .o_dl      (w_dl[i]),
            .o_tag     (w_tag[i])
        );
    end

    // ------------------------------------------------------------------
    // command sequencer
    always_comb begin
        n_state = r_state;
        n_time = r_time;
        n_count = r_count;
        n_n = r_n;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind = r_out_kind;
        n_out_tag = r_out_tag;
        n_out_armed = r_out_armed;
        n_out_last = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == OP_ADD) begin
                        n_state = w_full ? ST_REJECT : ST_INSERT;
                    end else begin
                        n_time = r_time + TIME_W'(1);
                        n_n = '0;
                        n_state = ST_EXPIRE;
                    end
                end
            end
            ST_INSERT: begin
                if (w_can_load) begin
                    n_count = r_count + CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_out_kind = KIND_ADD_OK;
                    n_out_tag = '0;
                    n_out_armed = 1'b1;
                    n_out_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_REJECT: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_kind = KIND_ADD_FULL;
                    n_out_tag = '0;
                    n_out_armed = (r_count != '0);
                    n_out_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EXPIRE: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    if (w_head_due) begin
                        n_count = r_count - CNT_W'(1);
                        n_n = r_n + RES_CNT_W'(1);
                        n_out_kind = KIND_EXPIRED;
                        n_out_tag = w_tag[0];
                        n_out_armed = (r_count > CNT_W'(1));
                        n_out_last = !w_next_due;
                        if (!w_next_due) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_out_kind = KIND_IDLE_TICK;
                        n_out_tag = '0;
                        n_out_armed = (r_count != '0);
                        n_out_last = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_time <= '0;
            r_count <= '0;
            r_n <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_time <= n_time;
            r_count <= n_count;
            r_n <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers: delay product, pending tag, output word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod <= TIME_W'(s_axis_tdata[47:16]) * TIME_W'(r_tps);
            r_tag <= s_axis_tdata[15:0];
        end
        r_out_kind <= n_out_kind;
        r_out_tag <= n_out_tag;
        r_out_armed <= n_out_armed;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {7'd0, r_out_armed, r_out_tag};
    assign m_axis_tuser = r_out_kind;
    assign m_axis_tlast = r_out_last;

    // ------------------------------------------------------------------
    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |-> !w_full)
        else $error("insert into a full queue");

    a_full_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser == OP_ADD) && w_full) |=> (r_state == ST_REJECT))
        else $error("add on full queue not rejected");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not shrink the queue");

endmodule

@@ tb/tb.sv @@
// ============================================================================
// tb
// Self-checking bench for the sorted deadline timer queue.
// ============================================================================
// Commands go in on s_axis: a tick, or an add with a tag and a delay. A
// scoreboard keeps its own sorted copy of the queue and of the time counter.
// From that copy it predicts the result words of every accepted command and
// checks each word that leaves m_axis against them, field by field.
// ticks_per_second is reprogrammed over APB only between phases, once all
// expected words are back. Most phases insert random idle cycles on both sides.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import sdtq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [2:0] ADDR_TPS = {REG_IDX_TPS, 2'b00};
    // word address one past the only register
    localparam logic [2:0] ADDR_SPARE = 3'd4;
    localparam logic [31:0] TPS_MAX = 32'hFFFF_FFFF;

    // one result word as seen on m_axis
    typedef struct packed {
        t_kind kind;
        t_tag  tag;
        logic  armed;
        logic  last;
    } t_timer_word;

    // ------------------------------------------------------------------------
    // Scoreboard: sorted queue copy, time counter and expected result words
    // ------------------------------------------------------------------------
    class timer_queue_scoreboard;
        t_time       now_ticks;
        t_time       dl_sorted[$];
        t_tag        tag_sorted[$];
        logic [31:0] tps;
        t_timer_word pending_words[$];
        int          depth;
        int          errors;

        function new(int depth_i);
            depth = depth_i;
            now_ticks = '0;
            tps = TPS_RESET;
            errors = 0;
        endfunction

        function bit busy();
            return pending_words.size() != 0;
        endfunction

        function void push_word(t_kind kind, t_tag tag, logic armed, logic last);
            t_timer_word w;
            w.kind = kind;
            w.tag = tag;
            w.armed = armed;
            w.last = last;
            pending_words.push_back(w);
        endfunction

        // predicts the result words of one accepted command
        function void note_command(logic op, t_tag tag, logic [31:0] delay_s);
            t_time deadline;
            t_time span;
            int    pos;
            int    n;
            t_tag  gone[$];
            if (op == OP_ADD) begin
                if (dl_sorted.size() >= depth) begin
                    push_word(KIND_ADD_FULL, '0, dl_sorted.size() != 0, 1'b1);
                end else begin
                    span = t_time'(delay_s) * t_time'(tps);
                    deadline = now_ticks + span;
                    // equal deadlines stay in arrival order
                    pos = 0;
                    while (pos < dl_sorted.size() && dl_sorted[pos] <= deadline)
                        pos++;
                    dl_sorted.insert(pos, deadline);
                    tag_sorted.insert(pos, tag);
                    push_word(KIND_ADD_OK, '0, 1'b1, 1'b1);
                end
            end else begin
                now_ticks = now_ticks + 1;
                n = 0;
                while (n < MAX_RESULTS && dl_sorted.size() > 0 &&
                       dl_sorted[0] <= now_ticks) begin
                    gone.push_back(tag_sorted.pop_front());
                    void'(dl_sorted.pop_front());
                    n++;
                end
                if (n == 0) begin
                    push_word(KIND_IDLE_TICK, '0, dl_sorted.size() != 0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        push_word(KIND_EXPIRED, gone[i],
                                  (dl_sorted.size() + n - 1 - i) != 0, i == n - 1);
                end
            end
        endfunction

        // compares one accepted result word with the oldest expectation
        function void check_word(t_kind kind, t_tag tag, logic armed, logic last);
            t_timer_word w;
            if (pending_words.size() == 0) begin
                $error("unexpected result word: kind %0d tag %h", kind, tag);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (kind !== w.kind) begin
                $error("result_kind: expected %0d, got %0d", w.kind, kind);
                errors++;
            end
            if (tag !== w.tag) begin
                $error("expired_tag: expected %h, got %h", w.tag, tag);
                errors++;
            end
            if (armed !== w.armed) begin
                $error("timer_armed: expected %b, got %b", w.armed, armed);
                errors++;
            end
            if (last !== w.last) begin
                $error("last_result: expected %b, got %b", w.last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // [15:0] task_tag, [47:16] delay_seconds
    logic        s_axis_tuser = OP_TICK; // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [15:0] expired_tag, [16] timer_armed, pad
    logic [1:0]  m_axis_tuser;        // [1:0] result_kind
    logic        m_axis_tlast;        // last_result
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    timer_queue_scoreboard sb;
    bit idle_on = 1'b0;

    sorted_deadline_timer_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks, each entered right after a rising edge
    // ------------------------------------------------------------------------

    // sends one command word; valid stays high until the next gap
    task automatic send_cmd(input logic op, input t_tag tag, input logic [31:0] delay_s);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {delay_s, tag};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(op, tag, delay_s);
    endtask

    // holds off the sender until every expected word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.busy()) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == REG_IDX_TPS)
            sb.tps = data;
    endtask

    task automatic reg_check(input logic [2:0] addr, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("ticks_per_second: expected %h, got %h", want, prdata);
            sb.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // one random command; short delays so most tasks expire during the run
    task automatic send_random();
        logic        op;
        logic [31:0] delay_s;
        op = ($urandom_range(0, 99) < 50) ? OP_ADD : OP_TICK;
        if (sb.tps == 0)
            delay_s = $urandom;
        else if ($urandom_range(0, 7) == 0)
            delay_s = $urandom_range(0, 30);
        else
            delay_s = $urandom_range(0, 6);
        send_cmd(op, t_tag'($urandom), delay_s);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, then check each accepted word
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[16],
                          m_axis_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] phase_tps[4];
        sb = new(DEPTH);
        phase_tps[0] = 32'd1;
        phase_tps[1] = 32'd2;
        phase_tps[2] = 32'd0;
        phase_tps[3] = $urandom_range(1, 4);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset rate: zero delay is due at the next tick, ties leave in order
        reg_check(ADDR_TPS, TPS_RESET);
        idle_on = 1'b1;
        send_cmd(OP_TICK, '0, '0);
        send_cmd(OP_ADD, 16'hFFFF, '0);
        send_cmd(OP_ADD, 16'h0000, '0);
        send_cmd(OP_TICK, '0, '0);
        send_cmd(OP_TICK, '0, '0);

        // highest rate
        wait_drained();
        reg_write(ADDR_TPS, TPS_MAX);
        send_cmd(OP_ADD, 16'h8001, '0);
        send_cmd(OP_TICK, '0, '0);

        // zero rate: any delay is due at the next tick
        wait_drained();
        reg_write(ADDR_TPS, 32'd0);
        send_cmd(OP_ADD, 16'h0F0F, 32'hFFFF_FFFF);
        send_cmd(OP_ADD, 16'h00F0, 32'd1);
        send_cmd(OP_TICK, '0, '0);

        // fill the queue, one rejected add, then all sixteen due at one tick
        wait_drained();
        reg_write(ADDR_TPS, 32'd1);
        reg_write(ADDR_SPARE, 32'h0000_0055);
        reg_check(ADDR_TPS, 32'd1);
        idle_on = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            send_cmd(OP_ADD, t_tag'(16'h1111 * i + i), 32'd2);
        send_cmd(OP_ADD, 16'hBEEF, 32'd0);
        send_cmd(OP_TICK, '0, '0);
        send_cmd(OP_TICK, '0, '0);

        // random phases, each at its own rate
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            reg_write(ADDR_TPS, phase_tps[p]);
            idle_on = (p != 1);
            repeat (19) send_random();
        end

        // largest products last, since those tasks never come due
        wait_drained();
        reg_write(ADDR_TPS, TPS_MAX);
        idle_on = 1'b1;
        send_cmd(OP_ADD, 16'h7E57, 32'hFFFF_FFFF);
        send_cmd(OP_ADD, 16'h0001, 32'd1);
        send_cmd(OP_ADD, 16'h0002, 32'd0);
        send_cmd(OP_TICK, '0, '0);
        send_cmd(OP_TICK, '0, '0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && !sb.busy())
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
